FILE: design/puct_batch_visit_distributor_core_macros.svh
// Assertion macros for the PUCT batch visit distributor.
// Depends on nothing; taken in by the top level.
`ifndef PUCT_BATCH_VISIT_DISTRIBUTOR_CORE_MACROS_SVH
`define PUCT_BATCH_VISIT_DISTRIBUTOR_CORE_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define PBVD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define PBVD_ASSERT_IMPLY(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/pbvd_pkg.sv
// Types and constants of the PUCT batch visit distributor.
// Depends on nothing; used by every module of the block.
`default_nettype none
package pbvd_pkg;
    localparam int P_W     = 16;
    localparam int Q_W     = 16;
    localparam int N_W     = 32;
    localparam int B_W     = 16;
    localparam int PAR_W   = 32;
    localparam int SLOT_W  = 6;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 4;
    localparam int RAD_W   = 48;
    localparam int ROOT_W  = 24;
    localparam int FACT_W  = 40;
    localparam int NUM_W   = 56;
    localparam int DEN_W   = 33;
    localparam int SCORE_W = 57;

    localparam logic [CIDX_W-1:0] CFG_EXPLORE_GAIN   = 4'd0;
    localparam logic [CIDX_W-1:0] CFG_ROUND_FRACTION = 4'd1;
    localparam logic [CFG_W-1:0]  EXPLORE_GAIN_RST   = 16'd7148;
    localparam logic [CFG_W-1:0]  ROUND_FRACTION_RST = 16'd26214;

    typedef struct packed {
        logic [P_W-1:0]   prior;
        logic [Q_W-1:0]   value_est;
        logic [N_W-1:0]   edge_visits_in;
        logic             final_edge;
        logic [B_W-1:0]   batch_visits;
        logic [PAR_W-1:0] parent_visits;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] edge_slot;
        logic [B_W-1:0]    granted_visits;
        logic              last_out;
    } t_out_item;

    typedef struct packed {
        logic [P_W-1:0] prior;
        logic [Q_W-1:0] value_est;
        logic [N_W-1:0] visits;
    } t_edge_rec;

    typedef enum logic [3:0] {
        ST_LOAD, ST_SINGLE, ST_SQRT_GO, ST_SQRT, ST_FACTOR, ST_SHARE, ST_RD, ST_MUL,
        ST_DIV_GO, ST_DIV, ST_CMP, ST_GRANT, ST_OUT_RD, ST_OUT_LD
    } t_state;
endpackage
`default_nettype wire

FILE: design/pbvd_store.sv
// Edge store and grant store: synchronous memories with a registered read.
// Depends on pbvd_pkg.
`default_nettype none
module pbvd_store #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  wire                            i_clk,
    input  wire                            i_edge_we,
    input  wire [IDX_W-1:0]                i_edge_waddr,
    input  wire pbvd_pkg::t_edge_rec       i_edge_wdata,
    input  wire                            i_grant_we,
    input  wire [IDX_W-1:0]                i_grant_waddr,
    input  wire [pbvd_pkg::B_W-1:0]        i_grant_wdata,
    input  wire                            i_re,
    input  wire [IDX_W-1:0]                i_raddr,
    output pbvd_pkg::t_edge_rec            o_edge_rdata,
    output logic [pbvd_pkg::B_W-1:0]       o_grant_rdata
);
    pbvd_pkg::t_edge_rec       r_edge_mem  [DEPTH];
    logic [pbvd_pkg::B_W-1:0]  r_grant_mem [DEPTH];

    // Write edge records at load time
    always_ff @(posedge i_clk) begin
        if (i_edge_we) begin
            r_edge_mem[i_edge_waddr] <= i_edge_wdata;
        end
    end

    // Write grant counts
    always_ff @(posedge i_clk) begin
        if (i_grant_we) begin
            r_grant_mem[i_grant_waddr] <= i_grant_wdata;
        end
    end

    // Registered read; data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_edge_rdata  <= r_edge_mem[i_raddr];
            o_grant_rdata <= r_grant_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

FILE: design/pbvd_sqrt.sv
// Iterative floor square root, two radicand bits per cycle.
// Depends on pbvd_pkg.
`default_nettype none
module pbvd_sqrt (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    input  wire [pbvd_pkg::RAD_W-1:0]      i_radicand,
    output logic                           o_done,
    output logic [pbvd_pkg::ROOT_W-1:0]    o_root
);
    localparam int REM_W = pbvd_pkg::ROOT_W + 1;

    logic [pbvd_pkg::RAD_W-1:0] r_rad;
    logic [REM_W-1:0]           r_rem;
    logic [4:0]                 r_steps;
    logic                       r_busy;
    logic [REM_W+1:0]           n_shift;
    logic [REM_W+1:0]           n_trial;
    logic                       n_ge;

    // Form the trial subtraction for this step
    always_comb begin
        n_shift = {r_rem, r_rad[pbvd_pkg::RAD_W-1 -: 2]};
        n_trial = {1'b0, o_root, 2'b01};
        n_ge    = (n_shift >= n_trial);
    end

    // Advance one root bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            o_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_rad   <= i_radicand;
                r_rem   <= '0;
                o_root  <= '0;
                r_steps <= 5'(pbvd_pkg::ROOT_W - 1);
            end else if (r_busy) begin
                r_rad  <= {r_rad[pbvd_pkg::RAD_W-3:0], 2'b00};
                r_rem  <= n_ge ? REM_W'(n_shift - n_trial) : REM_W'(n_shift);
                o_root <= {o_root[pbvd_pkg::ROOT_W-2:0], n_ge};
                if (r_steps == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_steps <= r_steps - 5'd1;
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: design/pbvd_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pbvd_pkg.
`default_nettype none
module pbvd_div (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    input  wire [pbvd_pkg::NUM_W-1:0]      i_num,
    input  wire [pbvd_pkg::DEN_W-1:0]      i_den,
    output logic                           o_done,
    output logic [pbvd_pkg::NUM_W-1:0]     o_quot
);
    localparam int DW = pbvd_pkg::DEN_W;

    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [5:0]    r_steps;
    logic          r_busy;
    logic [DW:0]   n_shift;
    logic          n_ge;

    // Shift in the next dividend bit and compare
    always_comb begin
        n_shift = {r_rem, o_quot[pbvd_pkg::NUM_W-1]};
        n_ge    = (n_shift >= {1'b0, r_den});
    end

    // Advance one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            o_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_den   <= i_den;
                r_rem   <= '0;
                o_quot  <= i_num;
                r_steps <= 6'(pbvd_pkg::NUM_W - 1);
            end else if (r_busy) begin
                r_rem  <= n_ge ? DW'(n_shift - {1'b0, r_den}) : DW'(n_shift);
                o_quot <= {o_quot[pbvd_pkg::NUM_W-2:0], n_ge};
                if (r_steps == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_steps <= r_steps - 6'd1;
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: design/puct_batch_visit_distributor_core.sv
// Top level of the PUCT batch visit distributor: control sequencer and ports.
// Depends on pbvd_pkg, pbvd_store, pbvd_sqrt, pbvd_div and the macros header.
//
// A non-final edge is written into the edge store. A lone edge takes the
// whole batch; else the final edge starts distribution: the square root is
// started and awaited, then the factor is formed. Each round forms the share
// and then, per edge, does one memory read, one multiply, a divider start,
// the 56-step divider and a compare; per round the grant is written back.
// Then one result per edge follows. The shared divider sets the pace.
// Configuration is taken only while the block loads edges. No clearing pass
// is needed after reset.
`default_nettype none
`include "puct_batch_visit_distributor_core_macros.svh"
module puct_batch_visit_distributor_core #(
    parameter int MAX_EDGES = 64
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire pbvd_pkg::t_in_item          i_in_data,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output pbvd_pkg::t_out_item              o_out_data,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [pbvd_pkg::CIDX_W-1:0]       i_cfg_index,
    input  wire [pbvd_pkg::CFG_W-1:0]        i_cfg_data
);
    localparam int IDX_W = $clog2(MAX_EDGES);
    localparam int CNT_W = $clog2(MAX_EDGES + 1);

    pbvd_pkg::t_state                 r_state, n_state;
    logic [pbvd_pkg::CFG_W-1:0]       r_gain, r_frac;
    logic [CNT_W-1:0]                 r_cnt;
    logic [IDX_W-1:0]                 r_idx, r_best;
    logic [pbvd_pkg::B_W-1:0]         r_rem, r_share, r_best_grant, r_gv;
    logic [pbvd_pkg::PAR_W-1:0]       r_parent;
    logic [pbvd_pkg::FACT_W-1:0]      r_factor;
    logic [pbvd_pkg::NUM_W-1:0]       r_num;
    logic [pbvd_pkg::DEN_W-1:0]       r_den;
    logic [pbvd_pkg::Q_W-1:0]         r_qv;
    logic [pbvd_pkg::SCORE_W-1:0]     r_top_score;
    logic                             r_out_valid;
    pbvd_pkg::t_out_item              r_out;

    logic                             in_acc, out_acc, out_free;
    logic                             edge_we, grant_we, mem_re;
    logic [IDX_W-1:0]                 grant_waddr, raddr;
    logic [pbvd_pkg::B_W-1:0]         grant_wdata;
    pbvd_pkg::t_edge_rec              edge_wdata, edge_rd;
    logic [pbvd_pkg::B_W-1:0]         grant_rd;
    logic                             sqrt_start, sqrt_done, div_start, div_done;
    logic [pbvd_pkg::ROOT_W-1:0]      root;
    logic [pbvd_pkg::NUM_W-1:0]       quot;
    logic [pbvd_pkg::SCORE_W-1:0]     score;
    logic [31:0]                      share_prod;
    logic [pbvd_pkg::B_W:0]           share_raw;
    logic [pbvd_pkg::B_W-1:0]         share;
    logic [CNT_W-1:0]                 cnt_next;
    logic                             is_last_idx;

    assign o_in_ready  = (r_state == pbvd_pkg::ST_LOAD);
    assign o_cfg_ready = (r_state == pbvd_pkg::ST_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = r_out_valid && i_out_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign is_last_idx = ({1'b0, r_idx} == CNT_W'(r_cnt - CNT_W'(1)));
    assign cnt_next    = (r_cnt < CNT_W'(MAX_EDGES)) ? CNT_W'(r_cnt + CNT_W'(1)) : r_cnt;

    // Round share: ceiling of remaining times fraction, clamped to [1, remaining]
    always_comb begin
        share_prod = {16'd0, r_rem} * {16'd0, r_frac};
        share_raw  = 17'((share_prod + 32'h0000_FFFF) >> 16);
        if (share_raw == '0) begin
            share = 16'd1;
        end else if (share_raw > {1'b0, r_rem}) begin
            share = r_rem;
        end else begin
            share = share_raw[pbvd_pkg::B_W-1:0];
        end
    end

    // Edge score: exploration term plus biased value
    assign score = {1'b0, quot}
                 + (pbvd_pkg::SCORE_W'({~r_qv[pbvd_pkg::Q_W-1], r_qv[pbvd_pkg::Q_W-2:0]}) << 21);

    assign edge_wdata = '{prior: i_in_data.prior, value_est: i_in_data.value_est,
                          visits: i_in_data.edge_visits_in};

    // Next state and memory controls
    always_comb begin
        n_state     = r_state;
        edge_we     = 1'b0;
        grant_we    = 1'b0;
        grant_waddr = r_cnt[IDX_W-1:0];
        grant_wdata = '0;
        mem_re      = 1'b0;
        raddr       = r_idx;
        sqrt_start  = 1'b0;
        div_start   = 1'b0;
        case (r_state)
            pbvd_pkg::ST_LOAD: begin
                if (in_acc) begin
                    edge_we  = (r_cnt < CNT_W'(MAX_EDGES));
                    grant_we = edge_we;
                    if (i_in_data.final_edge) begin
                        n_state = (cnt_next == CNT_W'(1)) ? pbvd_pkg::ST_SINGLE
                                                          : pbvd_pkg::ST_SQRT_GO;
                    end
                end
            end
            pbvd_pkg::ST_SINGLE: begin
                grant_we    = 1'b1;
                grant_waddr = '0;
                grant_wdata = r_rem;
                n_state     = pbvd_pkg::ST_OUT_RD;
            end
            pbvd_pkg::ST_SQRT_GO: begin
                sqrt_start = 1'b1;
                n_state    = pbvd_pkg::ST_SQRT;
            end
            pbvd_pkg::ST_SQRT: begin
                if (sqrt_done) begin
                    n_state = pbvd_pkg::ST_FACTOR;
                end
            end
            pbvd_pkg::ST_FACTOR: n_state = pbvd_pkg::ST_SHARE;
            pbvd_pkg::ST_SHARE: begin
                n_state = (r_rem == '0) ? pbvd_pkg::ST_OUT_RD : pbvd_pkg::ST_RD;
            end
            pbvd_pkg::ST_RD: begin
                mem_re  = 1'b1;
                n_state = pbvd_pkg::ST_MUL;
            end
            pbvd_pkg::ST_MUL: n_state = pbvd_pkg::ST_DIV_GO;
            pbvd_pkg::ST_DIV_GO: begin
                div_start = 1'b1;
                n_state   = pbvd_pkg::ST_DIV;
            end
            pbvd_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = pbvd_pkg::ST_CMP;
                end
            end
            pbvd_pkg::ST_CMP: begin
                n_state = is_last_idx ? pbvd_pkg::ST_GRANT : pbvd_pkg::ST_RD;
            end
            pbvd_pkg::ST_GRANT: begin
                grant_we    = 1'b1;
                grant_waddr = r_best;
                grant_wdata = r_best_grant + r_share;
                n_state     = pbvd_pkg::ST_SHARE;
            end
            pbvd_pkg::ST_OUT_RD: begin
                mem_re  = 1'b1;
                n_state = pbvd_pkg::ST_OUT_LD;
            end
            pbvd_pkg::ST_OUT_LD: begin
                if (out_free) begin
                    n_state = is_last_idx ? pbvd_pkg::ST_LOAD : pbvd_pkg::ST_OUT_RD;
                end
            end
            default: n_state = pbvd_pkg::ST_LOAD;
        endcase
    end

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbvd_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= pbvd_pkg::EXPLORE_GAIN_RST;
            r_frac <= pbvd_pkg::ROUND_FRACTION_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == pbvd_pkg::CFG_EXPLORE_GAIN) begin
                r_gain <= i_cfg_data;
            end else if (i_cfg_index == pbvd_pkg::CFG_ROUND_FRACTION) begin
                r_frac <= i_cfg_data;
            end
        end
    end

    // Count loaded edges and drive the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_cnt <= cnt_next;
            end
            if (r_state == pbvd_pkg::ST_OUT_LD && out_free) begin
                r_out_valid <= 1'b1;
                if (is_last_idx) begin
                    r_cnt <= '0;
                end
            end
        end
    end

    // Advance the datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            pbvd_pkg::ST_LOAD: begin
                r_rem    <= i_in_data.batch_visits;
                r_parent <= i_in_data.parent_visits;
                r_idx    <= '0;
            end
            pbvd_pkg::ST_FACTOR: r_factor <= {16'd0, root} * {24'd0, r_gain};
            pbvd_pkg::ST_SHARE: begin
                r_share <= share;
                r_idx   <= '0;
            end
            pbvd_pkg::ST_MUL: begin
                r_num <= {16'd0, r_factor} * {40'd0, edge_rd.prior};
                r_den <= pbvd_pkg::DEN_W'(1) + {1'b0, edge_rd.visits}
                       + {17'd0, grant_rd};
                r_qv  <= edge_rd.value_est;
                r_gv  <= grant_rd;
            end
            pbvd_pkg::ST_CMP: begin
                if (r_idx == '0 || score > r_top_score) begin
                    r_top_score  <= score;
                    r_best       <= r_idx;
                    r_best_grant <= r_gv;
                end
                r_idx <= r_idx + IDX_W'(1);
            end
            pbvd_pkg::ST_GRANT: r_rem <= r_rem - r_share;
            pbvd_pkg::ST_OUT_LD: begin
                if (out_free) begin
                    r_out.edge_slot      <= pbvd_pkg::SLOT_W'(r_idx);
                    r_out.granted_visits <= grant_rd;
                    r_out.last_out       <= is_last_idx;
                    r_idx                <= r_idx + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    pbvd_store #(.DEPTH(MAX_EDGES), .IDX_W(IDX_W)) u_store (
        .i_clk         (i_clk),
        .i_edge_we     (edge_we),
        .i_edge_waddr  (r_cnt[IDX_W-1:0]),
        .i_edge_wdata  (edge_wdata),
        .i_grant_we    (grant_we),
        .i_grant_waddr (grant_waddr),
        .i_grant_wdata (grant_wdata),
        .i_re          (mem_re),
        .i_raddr       (raddr),
        .o_edge_rdata  (edge_rd),
        .o_grant_rdata (grant_rd)
    );

    pbvd_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand ({r_parent, 16'd0}),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    pbvd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    `PBVD_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(MAX_EDGES), "edge count overflow")
    `PBVD_ASSERT_IMPLY(a_scan_has_work, i_clk, i_rst_n, r_state == pbvd_pkg::ST_RD, r_rem != '0 && r_share <= r_rem && r_share != '0, "round scan with bad share")
    `PBVD_ASSERT_IMPLY(a_scan_in_range, i_clk, i_rst_n, r_state == pbvd_pkg::ST_RD || r_state == pbvd_pkg::ST_OUT_RD, CNT_W'(r_idx) < r_cnt, "edge index beyond loaded edges")

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Testbench for puct_batch_visit_distributor_core: directed and random edge sets,
// with a local allocation predictor and an in-order check of each result transaction.
// Depends on pbvd_pkg and the RTL of the block.
`default_nettype none
module tb;
    localparam int NODE_EDGES = 64;
    localparam longint CYCLE_LIMIT = 64'd3000000;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    pbvd_pkg::t_in_item i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    pbvd_pkg::t_out_item o_out_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [pbvd_pkg::CIDX_W-1:0] i_cfg_index;
    logic [pbvd_pkg::CFG_W-1:0] i_cfg_data;

    puct_batch_visit_distributor_core #(.MAX_EDGES(NODE_EDGES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Predictor state: configuration and the edges of the node being loaded
    logic [pbvd_pkg::CFG_W-1:0] gain_q412;
    logic [pbvd_pkg::CFG_W-1:0] frac_q016;
    logic [pbvd_pkg::P_W-1:0] node_prior [NODE_EDGES];
    logic [pbvd_pkg::Q_W-1:0] node_value [NODE_EDGES];
    logic [pbvd_pkg::N_W-1:0] node_count [NODE_EDGES];
    logic [pbvd_pkg::B_W-1:0] node_grant [NODE_EDGES];
    int edges_held;

    pbvd_pkg::t_out_item grants_due[$];
    int errors;
    longint cycles;
    bit hold_off;      // long receiver stall requested by a test
    bit stall_quiet;   // stretch with no receiver stall

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Count cycles and end the run on a hang
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver stall pattern, with a long hold-off on request
    initial begin
        int hold_left;
        i_out_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off && hold_left == 0) begin
                hold_left = 3000;
                hold_off = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_quiet) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        pbvd_pkg::t_out_item exp_item;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (grants_due.size() == 0) begin
                $error("unexpected result slot=%0d", o_out_data.edge_slot);
                errors++;
            end else begin
                exp_item = grants_due.pop_front();
                if (o_out_data.edge_slot !== exp_item.edge_slot) begin
                    $error("edge_slot exp %0d got %0d", exp_item.edge_slot,
                           o_out_data.edge_slot);
                    errors++;
                end
                if (o_out_data.granted_visits !== exp_item.granted_visits) begin
                    $error("granted_visits exp %0d got %0d", exp_item.granted_visits,
                           o_out_data.granted_visits);
                    errors++;
                end
                if (o_out_data.last_out !== exp_item.last_out) begin
                    $error("last_out exp %0d got %0d", exp_item.last_out,
                           o_out_data.last_out);
                    errors++;
                end
            end
        end
    end

    function automatic logic [63:0] root_q8(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 46;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 64'd0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] puct_score(int k, logic [63:0] factor);
        logic [63:0] denom;
        logic [63:0] u;
        logic [63:0] q;
        denom = 64'd1 + {32'd0, node_count[k]} + {48'd0, node_grant[k]};
        u = (factor * {48'd0, node_prior[k]}) / denom;
        q = {48'd0, node_value[k] ^ 16'h8000};
        return u + (q << 21);
    endfunction

    // Store one edge and, on the final edge, split the batch and queue results
    task automatic predict_allocation(pbvd_pkg::t_in_item it);
        logic [63:0] remaining;
        logic [63:0] factor;
        logic [63:0] share;
        logic [63:0] top_score;
        logic [63:0] sc;
        int best;
        pbvd_pkg::t_out_item r;
        if (edges_held < NODE_EDGES) begin
            node_prior[edges_held] = it.prior;
            node_value[edges_held] = it.value_est;
            node_count[edges_held] = it.edge_visits_in;
            node_grant[edges_held] = '0;
            edges_held++;
        end
        if (!it.final_edge) return;
        remaining = {48'd0, it.batch_visits};
        if (edges_held == 1) begin
            node_grant[0] = remaining[15:0];
        end else begin
            factor = root_q8({32'd0, it.parent_visits} << 16) * {48'd0, gain_q412};
            while (remaining > 64'd0) begin
                share = (remaining * {48'd0, frac_q016} + 64'hFFFF) >> 16;
                if (share == 64'd0) share = 64'd1;
                if (share > remaining) share = remaining;
                best = 0;
                top_score = puct_score(0, factor);
                for (int k = 1; k < edges_held; k++) begin
                    sc = puct_score(k, factor);
                    if (sc > top_score) begin
                        top_score = sc;
                        best = k;
                    end
                end
                node_grant[best] = node_grant[best] + share[15:0];
                remaining = remaining - share;
            end
        end
        for (int k = 0; k < edges_held; k++) begin
            r.edge_slot = k[pbvd_pkg::SLOT_W-1:0];
            r.granted_visits = node_grant[k];
            r.last_out = (k + 1 == edges_held);
            grants_due = {grants_due, r};
        end
        edges_held = 0;
    endtask

    // Offer one edge and hold it until accepted
    task automatic send_edge(pbvd_pkg::t_in_item it);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_allocation(it);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [pbvd_pkg::CIDX_W-1:0] idx,
                             logic [pbvd_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == pbvd_pkg::CFG_EXPLORE_GAIN) gain_q412 = val;
        else frac_q016 = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic pbvd_pkg::t_in_item rand_edge(bit fin, int bmax);
        pbvd_pkg::t_in_item it;
        it.prior = 16'($urandom);
        it.value_est = 16'($urandom);
        case ($urandom_range(0, 3))
            0: it.edge_visits_in = $urandom;
            1: it.edge_visits_in = 32'hFFFFFFFF;
            default: it.edge_visits_in = $urandom_range(0, 100);
        endcase
        it.final_edge = fin;
        it.batch_visits = 16'($urandom_range(0, bmax));
        it.parent_visits = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
        return it;
    endfunction

    // Send a node of a given edge count with random content and optional sender gaps
    task automatic send_node(int n, int bmax, bit gaps);
        for (int k = 0; k < n; k++) begin
            if (gaps && $urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            send_edge(rand_edge(k == n - 1, bmax));
        end
    endtask

    task automatic test_extremes();
        pbvd_pkg::t_in_item it;
        // single edge takes the whole batch
        it = rand_edge(1'b1, 65535);
        it.batch_visits = 16'hFFFF;
        send_edge(it);
        // zero batch
        send_edge(rand_edge(1'b0, 0));
        it = rand_edge(1'b1, 0);
        it.batch_visits = 16'd0;
        send_edge(it);
        // field extremes and a tie on identical edges
        it = '{prior: 16'hFFFF, value_est: 16'h7FFF, edge_visits_in: 32'd0,
               final_edge: 1'b0, batch_visits: 16'd0, parent_visits: 32'd0};
        send_edge(it);
        it.prior = 16'd0; it.value_est = 16'h8000; it.edge_visits_in = 32'hFFFFFFFF;
        send_edge(it);
        it.prior = 16'h8000; it.value_est = 16'h0000; it.edge_visits_in = 32'd5;
        send_edge(it);
        send_edge(it);
        it.final_edge = 1'b1; it.batch_visits = 16'd40;
        it.parent_visits = 32'hFFFFFFFF;
        send_edge(it);
        wait_drained();
    endtask

    task automatic test_store_full();
        // overflow the store; the dropped final edge still starts distribution
        send_node(NODE_EDGES + 2, 6, 1'b0);
        wait_drained();
    endtask

    task automatic test_config_sweep();
        write_reg(pbvd_pkg::CFG_ROUND_FRACTION, 16'd1);
        write_reg(pbvd_pkg::CFG_EXPLORE_GAIN, 16'hFFFF);
        send_node(3, 12, 1'b1);
        wait_drained();
        write_reg(pbvd_pkg::CFG_ROUND_FRACTION, 16'hFFFF);
        write_reg(pbvd_pkg::CFG_EXPLORE_GAIN, 16'd1);
        send_node(4, 2000, 1'b1);
        wait_drained();
        write_reg(pbvd_pkg::CFG_ROUND_FRACTION, pbvd_pkg::ROUND_FRACTION_RST);
        write_reg(pbvd_pkg::CFG_EXPLORE_GAIN, pbvd_pkg::EXPLORE_GAIN_RST);
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int k = 0; k < 6; k++) send_node($urandom_range(1, 4), 30, 1'b0);
        wait_drained();
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 115) begin
            int n;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
            stall_quiet = ($urandom_range(0, 3) == 0);
            send_node(n, ($urandom_range(0, 7) == 0) ? 65535 : 200, 1'b1);
            sent += n;
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 30)) @(negedge i_clk);
            if ($urandom_range(0, 11) == 0) begin
                wait_drained();
                write_reg(pbvd_pkg::CFG_EXPLORE_GAIN, 16'($urandom_range(1, 65535)));
                write_reg(pbvd_pkg::CFG_ROUND_FRACTION, 16'($urandom_range(16384, 65535)));
            end
        end
        stall_quiet = 1'b0;
        wait_drained();
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        hold_off = 1'b0;
        stall_quiet = 1'b0;
        edges_held = 0;
        gain_q412 = pbvd_pkg::EXPLORE_GAIN_RST;
        frac_q016 = pbvd_pkg::ROUND_FRACTION_RST;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = pbvd_pkg::CFG_EXPLORE_GAIN;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_store_full();
        test_config_sweep();
        test_backpressure();
        test_random();

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
+incdir+design
design/pbvd_pkg.sv
design/pbvd_store.sv
design/pbvd_sqrt.sv
design/pbvd_div.sv
design/puct_batch_visit_distributor_core.sv
dv/tb.sv
